// ===== rtl/ultrasonic_range_obstacle_stop_assert.svh =====
// assertion helpers for the ranging block
`ifndef ULTRASONIC_RANGE_OBSTACLE_STOP_ASSERT_SVH
`define ULTRASONIC_RANGE_OBSTACLE_STOP_ASSERT_SVH

`ifndef SYNTHESIS
`define URS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define URS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define URS_ASSERT(lbl, clk, rstn, prop, msg)
`define URS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/urs_pkg.sv =====
`timescale 1ns / 1ps

package urs_pkg;

  localparam int unsigned TimeoutW = 20;
  localparam int unsigned DistW    = 14;
  localparam int unsigned DutyW    = 11;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [TimeoutW-1:0] EchoTimeoutRst = 20'd300000;
  localparam logic [DistW-1:0]    StopDistRst    = 14'd10;
  localparam logic [DutyW-1:0]    RunDutyRst     = 11'd850;
  localparam logic [ScaleW-1:0]   CmScaleRst     = 16'd2248;

  localparam int unsigned         TrigLowTicks  = 2;
  localparam int unsigned         TrigHighTicks = 10;
  localparam logic [DutyW-1:0]    PwmPeriod     = 11'd1700;
  localparam logic [DistW-1:0]    DistMax       = 14'd16383;

  typedef enum logic [CfgIdxW-1:0] {
    RegEchoTimeout = 3'd0,
    RegStopDist    = 3'd1,
    RegRunDuty     = 3'd2,
    RegCmScale     = 3'd3
  } cfg_reg_e;

endpackage

// ===== rtl/urs_if.sv =====
`timescale 1ns / 1ps

// one tick of the timebase with the sampled echo level
interface urs_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, start_req, echo, input ready);
  modport sink   (input valid, start_req, echo, output ready);
endinterface

// per-tick result
interface urs_res_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger;
  logic                       done_res;
  logic [urs_pkg::DistW-1:0]  distance_cm;
  logic                       timed_out;
  logic                       busy_res;
  logic                       dir_forward;
  logic [urs_pkg::DutyW-1:0]  pwm_duty;

  modport source (output valid, trigger, done_res, distance_cm, timed_out, busy_res,
                  dir_forward, pwm_duty, input ready);
  modport sink   (input valid, trigger, done_res, distance_cm, timed_out, busy_res,
                  dir_forward, pwm_duty, output ready);
endinterface

// register write channel
interface urs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [urs_pkg::CfgIdxW-1:0]  index;
  logic [urs_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/urs_dist.sv =====
`timescale 1ns / 1ps

// echo width to centimetres and the obstacle decision
module urs_dist #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic [COUNT_BITS-1:0]          echo_width_i,
  input  logic [urs_pkg::ScaleW-1:0]     cm_scale_i,
  input  logic [urs_pkg::DistW-1:0]      stop_dist_i,
  output logic [urs_pkg::DistW-1:0]      distance_o,
  output logic                           run_o
);

  localparam int unsigned ProdW = COUNT_BITS + urs_pkg::ScaleW;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] quo;

  assign prod = ProdW'(echo_width_i) * ProdW'(cm_scale_i);
  // drop the q0.16 fraction
  assign quo  = prod >> urs_pkg::ScaleW;

  assign distance_o = (quo > ProdW'(urs_pkg::DistMax)) ? urs_pkg::DistMax
                                                         : quo[urs_pkg::DistW-1:0];
  assign run_o      = distance_o > stop_dist_i;

endmodule

// ===== rtl/ultrasonic_range_obstacle_stop.sv =====
`timescale 1ns / 1ps

// channel | dir | payload                                   | accepted when
// in_i    | in  | start_req, echo                           | valid && ready
// res_o   | out | trigger, done_res, distance_cm, timed_out, | valid && ready
//         |     | busy_res, dir_forward, pwm_duty           |
// cfg_i   | in  | index, data                               | valid && ready
//
// one tick per cycle: each accepted tick updates the ranging state and loads
// the result register in the same cycle; the echo width multiply is the longest path
// a held result stalls input only while res_o.ready is low
// cfg_i is always ready; reset loads the register defaults and idles the sequencer
module ultrasonic_range_obstacle_stop #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  urs_in_if.sink       in_i,
  urs_res_if.source    res_o,
  urs_cfg_if.sink      cfg_i
);

`include "ultrasonic_range_obstacle_stop_assert.svh"

  localparam int unsigned CmpW = (COUNT_BITS > urs_pkg::TimeoutW) ? COUNT_BITS
                                                                   : urs_pkg::TimeoutW;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhTLow  = 3'd1,
    PhTHigh = 3'd2,
    PhWait  = 3'd3,
    PhCount = 3'd4
  } phase_e;

  // configuration
  logic [urs_pkg::TimeoutW-1:0] echo_timeout_q;
  logic [urs_pkg::DistW-1:0]    stop_dist_q;
  logic [urs_pkg::DutyW-1:0]    run_duty_q;
  logic [urs_pkg::ScaleW-1:0]   cm_scale_q;

  // ranging state
  phase_e                   phase_q, phase_d;
  logic [COUNT_BITS-1:0]    ticks_q, ticks_d;
  logic [COUNT_BITS-1:0]    width_q, width_d;
  logic [urs_pkg::DistW-1:0] dist_q, dist_d;
  logic                     tmo_q, tmo_d;
  logic                     run_q, run_d;

  // result register
  logic                      out_valid_q;
  logic                      trig_q;
  logic                      done_q;
  logic [urs_pkg::DutyW-1:0] pwm_q;

  logic                      trig_d, done_d;
  logic [urs_pkg::DutyW-1:0] pwm_d;
  logic [CmpW-1:0]           limit;
  logic [urs_pkg::DistW-1:0] calc_dist;
  logic                      calc_run;
  logic                      in_fire, cfg_fire;

  assign in_i.ready  = !out_valid_q || res_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // a zero timeout behaves as one
  assign limit = (echo_timeout_q == '0) ? CmpW'(1) : CmpW'(echo_timeout_q);

  function automatic logic limit_hit(input logic [COUNT_BITS-1:0] cnt,
                                     input logic [CmpW-1:0] lim);
    return (CmpW'(cnt) >= lim) || (&cnt);
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] cnt);
    return (&cnt) ? cnt : cnt + COUNT_BITS'(1);
  endfunction

  urs_dist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dist (
    .echo_width_i (width_q),
    .cm_scale_i   (cm_scale_q),
    .stop_dist_i  (stop_dist_q),
    .distance_o   (calc_dist),
    .run_o        (calc_run)
  );

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    width_d = width_q;
    dist_d  = dist_q;
    tmo_d   = tmo_q;
    run_d   = run_q;
    trig_d  = 1'b0;
    done_d  = 1'b0;

    // a start is taken on the same tick it arrives
    if (phase_q == PhIdle && in_i.start_req) begin
      phase_d = PhTLow;
      ticks_d = '0;
      width_d = '0;
    end

    unique case (phase_d)
      PhIdle: begin
      end
      PhTLow: begin
        ticks_d = bump(ticks_d);
        if (CmpW'(ticks_d) >= CmpW'(urs_pkg::TrigLowTicks)) begin
          phase_d = PhTHigh;
          ticks_d = '0;
        end
      end
      PhTHigh: begin
        trig_d  = 1'b1;
        ticks_d = bump(ticks_d);
        if (CmpW'(ticks_d) >= CmpW'(urs_pkg::TrigHighTicks)) begin
          phase_d = PhWait;
          ticks_d = '0;
        end
      end
      PhWait: begin
        if (in_i.echo) begin
          width_d = COUNT_BITS'(1);
          phase_d = PhCount;
          ticks_d = '0;
          if (limit_hit(COUNT_BITS'(1), limit)) begin
            dist_d  = '0;
            tmo_d   = 1'b1;
            run_d   = 1'b0;
            phase_d = PhIdle;
            done_d  = 1'b1;
          end
        end else begin
          ticks_d = bump(ticks_d);
          if (limit_hit(ticks_d, limit)) begin
            dist_d  = '0;
            tmo_d   = 1'b1;
            run_d   = 1'b0;
            phase_d = PhIdle;
            ticks_d = '0;
            done_d  = 1'b1;
          end
        end
      end
      PhCount: begin
        if (in_i.echo) begin
          width_d = bump(width_q);
          if (limit_hit(width_d, limit)) begin
            dist_d  = '0;
            tmo_d   = 1'b1;
            run_d   = 1'b0;
            phase_d = PhIdle;
            ticks_d = '0;
            done_d  = 1'b1;
          end
        end else begin
          dist_d  = calc_dist;
          tmo_d   = 1'b0;
          run_d   = calc_run;
          phase_d = PhIdle;
          ticks_d = '0;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        ticks_d = '0;
      end
    endcase

    if (!run_d) begin
      pwm_d = '0;
    end else if (run_duty_q > urs_pkg::PwmPeriod) begin
      pwm_d = urs_pkg::PwmPeriod;
    end else begin
      pwm_d = run_duty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_timeout_q <= urs_pkg::EchoTimeoutRst;
      stop_dist_q    <= urs_pkg::StopDistRst;
      run_duty_q     <= urs_pkg::RunDutyRst;
      cm_scale_q     <= urs_pkg::CmScaleRst;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        urs_pkg::RegEchoTimeout: echo_timeout_q <= cfg_i.data[urs_pkg::TimeoutW-1:0];
        urs_pkg::RegStopDist:    stop_dist_q    <= cfg_i.data[urs_pkg::DistW-1:0];
        urs_pkg::RegRunDuty:     run_duty_q     <= cfg_i.data[urs_pkg::DutyW-1:0];
        urs_pkg::RegCmScale:     cm_scale_q     <= cfg_i.data[urs_pkg::ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      ticks_q     <= '0;
      width_q     <= '0;
      dist_q      <= '0;
      tmo_q       <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        ticks_q     <= ticks_d;
        width_q     <= width_d;
        dist_q      <= dist_d;
        tmo_q       <= tmo_d;
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      trig_q <= trig_d;
      done_q <= done_d;
      pwm_q  <= pwm_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.trigger     = trig_q;
  assign res_o.done_res    = done_q;
  assign res_o.distance_cm = dist_q;
  assign res_o.timed_out   = tmo_q;
  assign res_o.busy_res    = (phase_q != PhIdle);
  assign res_o.dir_forward = run_q;
  assign res_o.pwm_duty    = pwm_q;

  `URS_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (out_valid_q && !res_o.ready) |-> !in_i.ready, "input taken while a result is stalled")
  `URS_ASSERT(a_timeout_zero_dist, clk_i, rst_ni, (out_valid_q && tmo_q) |-> (dist_q == '0), "timeout reported with nonzero distance")
  `URS_ASSERT(a_pwm_needs_run, clk_i, rst_ni, (out_valid_q && pwm_q != '0) |-> run_q, "pwm driven while motor stopped")
  `URS_ASSERT_ALWAYS(a_done_idle, clk_i, (rst_ni && out_valid_q && done_q) |-> (phase_q == PhIdle), "measurement done but still busy")

endmodule

// ===== tb/ultrasonic_range_obstacle_stop_checker.sv =====
`timescale 1ns / 1ps

module ultrasonic_range_obstacle_stop_checker #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  urs_in_if           in_mon,
  urs_res_if          res_mon,
  urs_cfg_if          cfg_mon,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  import urs_pkg::*;

  typedef enum logic [2:0] {
    RangeIdle      = 3'd0,
    RangeTrigLow   = 3'd1,
    RangeTrigHigh  = 3'd2,
    RangeWaitEcho  = 3'd3,
    RangeCountEcho = 3'd4
  } range_phase_e;

  typedef struct packed {
    logic             trigger;
    logic             done;
    logic [DistW-1:0] dist_cm;
    logic             timed_out;
    logic             busy;
    logic             fwd;
    logic [DutyW-1:0] duty;
  } tick_res_t;

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};
  localparam int unsigned MaxPrinted = 40;

  // register copies
  logic [TimeoutW-1:0]   echo_timeout_q;
  logic [DistW-1:0]      stop_dist_q;
  logic [DutyW-1:0]      run_duty_q;
  logic [ScaleW-1:0]     cm_scale_q;

  // ranging state
  range_phase_e          phase_q;
  logic [COUNT_BITS-1:0] ticks_q;
  logic [COUNT_BITS-1:0] width_q;
  logic [DistW-1:0]      last_dist_q;
  logic                  last_tmo_q;
  logic                  motor_q;

  tick_res_t             expected_res_q[$];
  tick_res_t             want;
  int unsigned           res_seen;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] cnt);
    return (cnt == CntMax) ? CntMax : cnt + 1'b1;
  endfunction

  // a zero timeout behaves as one
  function automatic logic limit_hit(input logic [COUNT_BITS-1:0] cnt);
    logic [TimeoutW-1:0] lim;
    lim = (echo_timeout_q == '0) ? TimeoutW'(1) : echo_timeout_q;
    return (cnt >= lim) || (cnt == CntMax);
  endfunction

  task automatic end_measurement(input logic [DistW-1:0] dist_cm, input logic tmo);
    last_dist_q = dist_cm;
    last_tmo_q  = tmo;
    motor_q     = dist_cm > stop_dist_q;
    phase_q     = RangeIdle;
    ticks_q     = '0;
  endtask

  task automatic predict_tick(input logic start, input logic echo, output tick_res_t r);
    logic [COUNT_BITS+ScaleW-1:0] prod;
    logic [COUNT_BITS+ScaleW-1:0] dist_full;
    r = '0;
    if (phase_q == RangeIdle && start) begin
      phase_q = RangeTrigLow;
      ticks_q = '0;
      width_q = '0;
    end
    case (phase_q)
      RangeTrigLow: begin
        ticks_q = bump(ticks_q);
        if (ticks_q >= TrigLowTicks) begin
          phase_q = RangeTrigHigh;
          ticks_q = '0;
        end
      end
      RangeTrigHigh: begin
        r.trigger = 1'b1;
        ticks_q   = bump(ticks_q);
        if (ticks_q >= TrigHighTicks) begin
          phase_q = RangeWaitEcho;
          ticks_q = '0;
        end
      end
      RangeWaitEcho: begin
        if (echo) begin
          width_q = COUNT_BITS'(1);
          phase_q = RangeCountEcho;
          ticks_q = '0;
          if (limit_hit(width_q)) begin
            end_measurement('0, 1'b1);
            r.done = 1'b1;
          end
        end else begin
          ticks_q = bump(ticks_q);
          if (limit_hit(ticks_q)) begin
            end_measurement('0, 1'b1);
            r.done = 1'b1;
          end
        end
      end
      RangeCountEcho: begin
        if (echo) begin
          width_q = bump(width_q);
          if (limit_hit(width_q)) begin
            end_measurement('0, 1'b1);
            r.done = 1'b1;
          end
        end else begin
          prod      = width_q * cm_scale_q;
          dist_full = prod >> ScaleW;
          end_measurement((dist_full > DistMax) ? DistMax : dist_full[DistW-1:0], 1'b0);
          r.done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.dist_cm   = last_dist_q;
    r.timed_out = last_tmo_q;
    r.busy      = phase_q != RangeIdle;
    r.fwd       = motor_q;
    r.duty      = motor_q ? ((run_duty_q > PwmPeriod) ? PwmPeriod : run_duty_q) : '0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    if (err_count_o < MaxPrinted) begin
      $display("mismatch at result %0d: %s got %0d want %0d", res_seen, what, got, exp_val);
    end
    err_count_o++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned exp_val);
    if (got != exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_timeout_q = EchoTimeoutRst;
      stop_dist_q    = StopDistRst;
      run_duty_q     = RunDutyRst;
      cm_scale_q     = CmScaleRst;
      phase_q        = RangeIdle;
      ticks_q        = '0;
      width_q        = '0;
      last_dist_q    = '0;
      last_tmo_q     = 1'b0;
      motor_q        = 1'b0;
      expected_res_q.delete();
      err_count_o    = 0;
      pending_o      = 0;
      res_seen       = 0;
    end else begin
      // results first: a result taken at this edge belongs to an older request
      if (res_mon.valid && res_mon.ready) begin
        if (expected_res_q.size() == 0) begin
          report_mismatch("result with no request pending", 0, 0);
        end else begin
          want = expected_res_q.pop_front();
          check_field("trigger", 32'(res_mon.trigger), 32'(want.trigger));
          check_field("done_res", 32'(res_mon.done_res), 32'(want.done));
          check_field("distance_cm", 32'(res_mon.distance_cm), 32'(want.dist_cm));
          check_field("timed_out", 32'(res_mon.timed_out), 32'(want.timed_out));
          check_field("busy_res", 32'(res_mon.busy_res), 32'(want.busy));
          check_field("dir_forward", 32'(res_mon.dir_forward), 32'(want.fwd));
          check_field("pwm_duty", 32'(res_mon.pwm_duty), 32'(want.duty));
        end
        res_seen++;
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          RegEchoTimeout: echo_timeout_q = cfg_mon.data[TimeoutW-1:0];
          RegStopDist:    stop_dist_q    = cfg_mon.data[DistW-1:0];
          RegRunDuty:     run_duty_q     = cfg_mon.data[DutyW-1:0];
          RegCmScale:     cm_scale_q     = cfg_mon.data[ScaleW-1:0];
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_tick(in_mon.start_req, in_mon.echo, want);
        expected_res_q.push_back(want);
      end
      pending_o = expected_res_q.size();
    end
  end

endmodule

// ===== tb/ultrasonic_range_obstacle_stop_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_range_obstacle_stop_tb;
  import urs_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned TicksPerPhase = 125;

  logic        clk_i;
  logic        rst_ni;
  int unsigned err_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned ticks_sent;
  int unsigned in_idle_pct;
  int unsigned res_idle_pct;

  urs_in_if  in_if ();
  urs_res_if res_if ();
  urs_cfg_if cfg_if ();

  ultrasonic_range_obstacle_stop i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  ultrasonic_range_obstacle_stop_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .res_mon     (res_if),
    .cfg_mon     (cfg_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res_if.ready = $urandom_range(99) >= res_idle_pct;
  end

  task automatic send_tick(input logic start, input logic echo);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.start_req = start;
    in_if.echo      = echo;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // start request, trigger ticks, echo-low wait, echo-high width, falling edge
  task automatic run_measurement(input int unsigned wait_n, input int unsigned width_n,
                                 input bit noisy);
    int unsigned k;
    send_tick(1'b1, noisy ? $urandom_range(1) : 1'b0);
    for (k = 0; k < TrigLowTicks + TrigHighTicks - 1; k++) begin
      send_tick(noisy ? $urandom_range(1) : 1'b0, noisy ? $urandom_range(1) : 1'b0);
    end
    for (k = 0; k < wait_n; k++) begin
      send_tick(noisy ? $urandom_range(1) : 1'b0, 1'b0);
    end
    for (k = 0; k < width_n; k++) begin
      send_tick(noisy ? $urandom_range(1) : 1'b0, 1'b1);
    end
    send_tick(1'b0, 1'b0);
  endtask

  // wait until every request has its result
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    @(negedge clk_i);
  endtask

  // random bits above the register width, which the block must drop
  function automatic logic [CfgDataW-1:0] pad_junk(input int unsigned value,
                                                   input int unsigned width);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'($urandom);
    d = (d >> width) << width;
    return d | CfgDataW'(value);
  endfunction

  task automatic random_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned width_n;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        width_n = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        run_measurement($urandom_range(0, 6), width_n, $urandom_range(3) == 0);
      end else begin
        repeat ($urandom_range(1, 8)) send_tick($urandom_range(1), $urandom_range(1));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    in_if.echo      = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    res_if.ready    = 1'b0;
    cycle_count     = 0;
    ticks_sent      = 0;
    in_idle_pct     = 28;
    res_idle_pct    = 82;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults after reset, start requests while busy, echo while idle
    run_measurement(3, 5, 1'b1);
    send_tick(1'b0, 1'b1);
    drain();

    write_reg(RegEchoTimeout, {TimeoutW{1'b1}});
    write_reg(RegStopDist, pad_junk(0, DistW));
    write_reg(RegRunDuty, pad_junk(2047, DutyW));
    write_reg(RegCmScale, pad_junk(65535, ScaleW));
    run_measurement(0, 20, 1'b0);
    drain();

    // the highest stop distance keeps the motor off
    write_reg(RegStopDist, pad_junk(32'(DistMax), DistW));
    run_measurement(2, 40, 1'b0);
    drain();

    // threshold boundary: equal stops, one above runs
    write_reg(RegStopDist, pad_junk(18, DistW));
    write_reg(RegRunDuty, pad_junk(32'(PwmPeriod), DutyW));
    run_measurement(1, 19, 1'b0);
    run_measurement(1, 20, 1'b0);
    drain();
    write_reg(RegRunDuty, pad_junk(0, DutyW));
    run_measurement(1, 30, 1'b0);
    drain();

    // no echo within the timeout, then echo held too long
    write_reg(RegEchoTimeout, CfgDataW'(5));
    run_measurement(8, 0, 1'b0);
    run_measurement(0, 7, 1'b0);
    drain();

    // zero timeout behaves as one
    write_reg(RegEchoTimeout, CfgDataW'(0));
    run_measurement(0, 1, 1'b0);
    run_measurement(1, 0, 1'b0);
    drain();
    write_reg(RegEchoTimeout, CfgDataW'(1));
    run_measurement(0, 2, 1'b0);
    drain();

    write_reg(RegEchoTimeout, CfgDataW'(50));
    write_reg(RegCmScale, pad_junk(0, ScaleW));
    run_measurement(2, 10, 1'b0);
    drain();

    // writes to unused indices change nothing
    for (int k = int'(RegCmScale) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), CfgDataW'($urandom));
    end
    write_reg(RegCmScale, pad_junk(40000, ScaleW));
    run_measurement(1, 10, 1'b0);
    drain();

    write_reg(RegEchoTimeout, CfgDataW'($urandom_range(150, 400)));
    write_reg(RegStopDist, pad_junk($urandom_range(0, 30), DistW));
    write_reg(RegRunDuty, pad_junk($urandom_range(0, 2047), DutyW));
    write_reg(RegCmScale, pad_junk($urandom_range(20000, 65535), ScaleW));
    random_traffic(TicksPerPhase);

    in_idle_pct  = 82;
    res_idle_pct = 28;
    // short timeout so both timeout kinds show up
    write_reg(RegEchoTimeout, CfgDataW'($urandom_range(6, 12)));
    write_reg(RegStopDist, pad_junk($urandom_range(0, 60), DistW));
    write_reg(RegRunDuty, pad_junk($urandom_range(0, 2047), DutyW));
    write_reg(RegCmScale, pad_junk($urandom_range(0, 65535), ScaleW));
    random_traffic(TicksPerPhase);

    in_idle_pct  = 0;
    res_idle_pct = 0;
    write_reg(RegEchoTimeout, {TimeoutW{1'b1}});
    write_reg(RegStopDist, pad_junk($urandom_range(0, 100), DistW));
    write_reg(RegRunDuty, pad_junk(32'(PwmPeriod), DutyW));
    write_reg(RegCmScale, pad_junk(65535, ScaleW));
    random_traffic(TicksPerPhase);

    repeat (8) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
